// File: src/rled_pkg.sv
// Shared types and constants for the planar run-length sprite decoder.
// No dependencies; every other file of the block imports this package.
package rled_pkg;

   localparam int HEADER_BYTES = 10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic        pixel_write;
      logic [15:0] pixel_address;
      logic [7:0]  pixel_value;
      logic        frame_done;
      logic        range_error;
   } rsp_type;

   // One decoded byte's outcome, handed from the parser to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type word;
   } result_type;

   // Unsigned 32-bit add that sticks at all ones instead of wrapping.
   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      sat_add32 = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

// File: src/rled_parser.sv
// Header, command and literal parser with the frame decode state.
// Depends on rled_pkg for the word types and the saturating add.
module rled_parser #(
   parameter int MAX_PIXELS  = 65536,
   parameter int PLANE_COUNT = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  rled_pkg::req_type    req_word,
   output rled_pkg::result_type result
);
   import rled_pkg::*;

   localparam int PIDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam logic [PIDX_W:0] PLANE_LAST = (PIDX_W + 1)'(PLANE_COUNT - 1);
   localparam logic [31:0] STRIDE = 32'(PLANE_COUNT);
   localparam logic [32:0] ADDR_LIMIT = 33'(MAX_PIXELS);
   localparam logic [3:0] HEADER_LAST = 4'(HEADER_BYTES - 1);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_COMMAND = 2'd2;
   localparam logic [1:0] PH_LITERAL = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [3:0]        hidx_ff, hidx_in;
   logic [15:0]       width_ff, width_in;
   logic [15:0]       height_ff, height_in;
   logic [PIDX_W-1:0] plane_ff, plane_in;
   logic [15:0]       rows_ff, rows_in;
   logic [31:0]       row_base_ff, row_base_in;
   logic [31:0]       col_ff, col_in;
   logic [6:0]        lit_ff, lit_in;

   logic [1:0]  phase_eff;
   logic [3:0]  hidx_eff;
   logic [7:0]  b;
   logic [32:0] addr;
   logic [31:0] skip;

   always_comb begin
      b         = req_word.data_byte;
      phase_eff = req_word.frame_start ? PH_HEADER : phase_ff;
      hidx_eff  = req_word.frame_start ? 4'd0 : hidx_ff;
      addr      = {1'b0, row_base_ff} + {1'b0, col_ff};
      skip      = 32'(9'd256 - {1'b0, b}) * STRIDE;

      phase_in    = phase_eff;
      hidx_in     = hidx_eff;
      width_in    = width_ff;
      height_in   = height_ff;
      plane_in    = plane_ff;
      rows_in     = rows_ff;
      row_base_in = row_base_ff;
      col_in      = col_ff;
      lit_in      = lit_ff;
      result      = '0;

      case (phase_eff)
         PH_HEADER: begin
            case (hidx_eff)
               4'd0:    width_in[7:0]   = b;
               4'd1:    width_in[15:8]  = b;
               4'd2:    height_in[7:0]  = b;
               4'd3:    height_in[15:8] = b;
               default: ;
            endcase
            hidx_in = hidx_eff + 4'd1;
            if (hidx_eff >= HEADER_LAST) begin
               hidx_in     = 4'd0;
               lit_in      = 7'd0;
               plane_in    = '0;
               rows_in     = height_ff;
               row_base_in = 32'd0;
               col_in      = 32'd0;
               if (height_ff == 16'd0) begin
                  phase_in              = PH_IDLE;
                  result.valid          = 1'b1;
                  result.word.frame_done = 1'b1;
               end else begin
                  phase_in = PH_COMMAND;
               end
            end
         end
         PH_COMMAND: begin
            if (b == 8'd0) begin
               rows_in     = rows_ff - 16'd1;
               row_base_in = sat_add32(row_base_ff, 32'(width_ff));
               col_in      = 32'(plane_ff);
               if (rows_ff == 16'd1) begin
                  if ((PIDX_W + 1)'(plane_ff) >= PLANE_LAST) begin
                     phase_in               = PH_IDLE;
                     result.valid           = 1'b1;
                     result.word.frame_done = 1'b1;
                  end else begin
                     // Next plane starts one column further right.
                     plane_in    = plane_ff + PIDX_W'(1);
                     rows_in     = height_ff;
                     row_base_in = 32'd0;
                     col_in      = 32'(plane_ff) + 32'd1;
                  end
               end
            end else if (b[7]) begin
               col_in = sat_add32(col_ff, skip);
            end else begin
               lit_in   = b[6:0];
               phase_in = PH_LITERAL;
            end
         end
         PH_LITERAL: begin
            col_in = sat_add32(col_ff, STRIDE);
            lit_in = lit_ff - 7'd1;
            if (lit_ff == 7'd1) begin
               phase_in = PH_COMMAND;
            end
            result.valid = 1'b1;
            if (addr >= ADDR_LIMIT) begin
               result.word.range_error = 1'b1;
            end else begin
               result.word.pixel_write   = 1'b1;
               result.word.pixel_address = addr[15:0];
               result.word.pixel_value   = b;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         hidx_ff     <= 4'd0;
         width_ff    <= 16'd0;
         height_ff   <= 16'd0;
         plane_ff    <= '0;
         rows_ff     <= 16'd0;
         row_base_ff <= 32'd0;
         col_ff      <= 32'd0;
         lit_ff      <= 7'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hidx_ff     <= hidx_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         plane_ff    <= plane_in;
         rows_ff     <= rows_in;
         row_base_ff <= row_base_in;
         col_ff      <= col_in;
         lit_ff      <= lit_in;
      end
   end

`ifndef SYNTHESIS
   a_header_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> hidx_ff <= HEADER_LAST)
      else $error("header index ran past the header");
   a_literal_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LITERAL |-> lit_ff != 7'd0)
      else $error("literal phase with no literals left");
   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      (PIDX_W + 1)'(plane_ff) <= PLANE_LAST)
      else $error("plane index out of range");
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> $countones({result.word.pixel_write, result.word.frame_done,
                                   result.word.range_error}) == 1)
      else $error("result word carries no or several kinds");
`endif
endmodule

// File: src/rled_rsp_reg.sv
// Output register for the decoder's result words.
// Depends on rled_pkg for the result types.
module rled_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  rled_pkg::result_type result,
   output logic                 slot_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rled_pkg::rsp_type    rsp_data
);
   import rled_pkg::*;

   logic    valid_ff;
   rsp_type word_ff;

   // The slot is free when empty or when its word leaves this cycle.
   assign slot_free = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept && result.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.valid) begin
         word_ff <= result.word;
      end
   end
endmodule

// File: src/planar_rle_sprite_decoder_top.sv
// Top level of the planar run-length sprite decoder.
// Depends on rled_pkg, rled_parser and rled_rsp_reg.
//
// Usage: one compressed frame byte enters per word on the req_ channel
// (valid/ready), with frame_start set on the first header byte. After the
// ten-byte header, PLANE_COUNT (default four) interleaved planes of row
// commands follow. Each literal byte yields one word on the rsp_ channel:
// a pixel write, or a range-error word when the address reaches
// MAX_PIXELS. The last row of the last plane, or a header with zero height,
// yields one frame-done word. Bytes outside a frame give no word.
// Throughput: one byte per cycle while req_ready is high, set by the single
// parse step between the decode state registers and the output register.
// Latency: a result word shows on rsp_ the cycle after its byte is accepted.
// Stall: req_ready stays high while the output register is empty or being
// taken; when the receiver holds rsp_ready low with a word waiting, req_ready
// drops until that word leaves.
// Reset (synchronous) empties the output register and leaves the decoder
// idle, waiting for frame_start.
module planar_rle_sprite_decoder_top #(
   parameter int MAX_PIXELS  = 65536,
   parameter int PLANE_COUNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rled_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rled_pkg::rsp_type rsp_data
);
   import rled_pkg::*;

   result_type result;
   logic       slot_free;
   logic       accept;

   assign req_ready = slot_free;
   assign accept    = req_valid && slot_free;

   rled_parser #(
      .MAX_PIXELS  (MAX_PIXELS),
      .PLANE_COUNT (PLANE_COUNT)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_data),
      .result   (result)
   );

   rled_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .result    (result),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
